// File: hdl/pbl_pkg.sv
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared types and constants for the palette blend lookup pipeline.
// ----------------------------------------------------------------------------
package pbl_pkg;

    localparam int unsigned DEF_PALETTE_ENTRIES = 256;
    localparam int unsigned DEF_COMPONENT_BITS  = 5;

    localparam int unsigned IDX_W      = 8;
    localparam int unsigned COMP_W     = 8;
    localparam int unsigned COLOR_W    = 3 * COMP_W;
    localparam int unsigned TBL_ADDR_W = 15;
    localparam int unsigned FAC_W      = 9;
    localparam int unsigned PROD_W     = 16;
    localparam int unsigned IN_DATA_W  = 64;

    localparam logic [FAC_W-1:0] FAC_FULL  = 9'd256;
    localparam logic [FAC_W-1:0] FAC_RESET = 9'd128;

    typedef enum logic [1:0] {
        MODE_PAL_WR = 2'd0,
        MODE_INV_WR = 2'd1,
        MODE_BLEND  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BLEND  = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_SECOND = 2'd2
    } kind_t;

    typedef struct packed {
        mode_t                 mode;
        logic [IDX_W-1:0]      first_index;
        logic [IDX_W-1:0]      second_index;
        logic [TBL_ADDR_W-1:0] table_address;
        logic [IDX_W-1:0]      table_value;
    } lookup_item_t;

    typedef struct packed {
        mode_t                         mode;
        kind_t                         kind;
        logic [IDX_W-1:0]              keep_index;
        logic [2:0][PROD_W-1:0]        prod_first;
        logic [2:0][PROD_W-1:0]        prod_second;
        logic [TBL_ADDR_W-1:0]         table_address;
        logic [IDX_W-1:0]              table_value;
    } mix_item_t;

endpackage

// File: hdl/palette_blend_lookup.sv
// ----------------------------------------------------------------------------
// palette_blend_lookup
// Palette translucency blend: palette and inverse palette loaded by write
// items, blend items return a palette index.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tdata: item fields, tuser: mode
//   m_*       out  m_tvalid/m_tready  tdata: blended_index, tuser: source_kind
//   cfg_*     in   cfg_valid/cfg_ready cfg_data: mix weight
//
// One item per cycle while the output is not stalled. An accepted item passes
// the palette read registers and the mix register before the result register loads.
// Stage 1 reads the palette memory twice, stage 2 weights the components,
// stage 3 reads the inverse palette memory into the result register.
// Reset clears the stage valids and sets the mix weight to 128; memories keep
// their contents. A stalled output fills the three stages, then s_tready drops.
// ----------------------------------------------------------------------------
module palette_blend_lookup
    import pbl_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int unsigned COMPONENT_BITS  = DEF_COMPONENT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // first_index, second_index, comp_low, comp_mid, comp_high,
    // table_address, table_value, one unused bit
    input  logic [IN_DATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // blended_index
    output logic [IDX_W-1:0]     m_tdata,
    // source_kind
    output logic [1:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [FAC_W-1:0]     cfg_data
);

    logic [FAC_W-1:0]   fac_reg;
    logic [FAC_W-1:0]   fac_next;
    logic [FAC_W-1:0]   fac_sat;

    lookup_item_t       in_item;
    logic [COLOR_W-1:0] in_color;

    logic               pal_valid;
    logic               pal_ready;
    lookup_item_t       pal_item;
    logic [COLOR_W-1:0] pal_color_first;
    logic [COLOR_W-1:0] pal_color_second;

    logic               mix_valid;
    logic               mix_ready;
    mix_item_t          mix_item;

    kind_t              res_kind;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        fac_next = fac_reg;
        if (cfg_valid && cfg_ready)
        begin
            fac_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fac_reg <= FAC_RESET;
        end
        else
        begin
            fac_reg <= fac_next;
        end
    end

    assign fac_sat = (fac_reg > FAC_FULL) ? FAC_FULL : fac_reg;

    assign in_item.mode          = mode_t'(s_tuser);
    assign in_item.first_index   = s_tdata[7:0];
    assign in_item.second_index  = s_tdata[15:8];
    assign in_color              = s_tdata[39:16];
    assign in_item.table_address = s_tdata[54:40];
    assign in_item.table_value   = s_tdata[62:55];

    pbl_palette_stage #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_item          (in_item),
        .in_color         (in_color),
        .out_valid        (pal_valid),
        .out_ready        (pal_ready),
        .out_item         (pal_item),
        .out_color_first  (pal_color_first),
        .out_color_second (pal_color_second)
    );

    pbl_mix_stage u_mix (
        .clk             (clk),
        .rst_n           (rst_n),
        .fac             (fac_sat),
        .in_valid        (pal_valid),
        .in_ready        (pal_ready),
        .in_item         (pal_item),
        .in_color_first  (pal_color_first),
        .in_color_second (pal_color_second),
        .out_valid       (mix_valid),
        .out_ready       (mix_ready),
        .out_item        (mix_item)
    );

    pbl_inverse_stage #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_inverse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_item   (mix_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (m_tdata),
        .out_kind  (res_kind)
    );

    assign m_tuser = res_kind;

endmodule

// File: hdl/pbl_palette_stage.sv
// ----------------------------------------------------------------------------
// pbl_palette_stage
// Palette memory with two registered read ports; palette writes at item acceptance.
// ----------------------------------------------------------------------------
module pbl_palette_stage
    import pbl_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lookup_item_t       in_item,
    input  logic [COLOR_W-1:0] in_color,
    output logic               out_valid,
    input  logic               out_ready,
    output lookup_item_t       out_item,
    output logic [COLOR_W-1:0] out_color_first,
    output logic [COLOR_W-1:0] out_color_second
);

    localparam int unsigned PAW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [COLOR_W-1:0] pal_mem [PALETTE_ENTRIES];
    logic [PAW-1:0]     slot_tbl [1 << IDX_W];

    logic               valid_reg;
    logic               valid_next;
    lookup_item_t       item_reg;
    logic [COLOR_W-1:0] color_first_reg;
    logic [COLOR_W-1:0] color_second_reg;
    logic               go;
    logic [PAW-1:0]     slot_first;
    logic [PAW-1:0]     slot_second;

    for (genvar g = 0; g < (1 << IDX_W); g++)
    begin : g_slot
        localparam int unsigned SLOT = g % PALETTE_ENTRIES;
        assign slot_tbl[g] = PAW'(SLOT);
    end

    assign in_ready    = !valid_reg || out_ready;
    assign go          = in_valid && in_ready;
    assign slot_first  = slot_tbl[in_item.first_index];
    assign slot_second = slot_tbl[in_item.second_index];

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            item_reg         <= in_item;
            color_first_reg  <= pal_mem[slot_first];
            color_second_reg <= pal_mem[slot_second];
            if (in_item.mode == MODE_PAL_WR)
            begin
                pal_mem[slot_first] <= in_color;
            end
        end
    end

    assign out_valid        = valid_reg;
    assign out_item         = item_reg;
    assign out_color_first  = color_first_reg;
    assign out_color_second = color_second_reg;

endmodule

// File: hdl/pbl_mix_stage.sv
// ----------------------------------------------------------------------------
// pbl_mix_stage
// Picks the kept index or blend case and registers the weighted components.
// ----------------------------------------------------------------------------
module pbl_mix_stage
    import pbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FAC_W-1:0]   fac,
    input  logic               in_valid,
    output logic               in_ready,
    input  lookup_item_t       in_item,
    input  logic [COLOR_W-1:0] in_color_first,
    input  logic [COLOR_W-1:0] in_color_second,
    output logic               out_valid,
    input  logic               out_ready,
    output mix_item_t          out_item
);

    logic             valid_reg;
    logic             valid_next;
    mix_item_t        item_reg;
    mix_item_t        item_next;
    logic             go;
    logic [FAC_W-1:0] bar;

    assign in_ready = !valid_reg || out_ready;
    assign go       = in_valid && in_ready;
    assign bar      = FAC_FULL - fac;

    always_comb
    begin
        item_next               = '0;
        item_next.mode          = in_item.mode;
        item_next.table_address = in_item.table_address;
        item_next.table_value   = in_item.table_value;
        if (in_item.first_index == '0 || in_item.first_index == in_item.second_index
            || in_color_first == '0)
        begin
            item_next.kind       = KIND_FIRST;
            item_next.keep_index = in_item.first_index;
        end
        else if (in_item.second_index == '0 || in_color_second == '0)
        begin
            item_next.kind       = KIND_SECOND;
            item_next.keep_index = in_item.second_index;
        end
        else
        begin
            item_next.kind       = KIND_BLEND;
            item_next.keep_index = in_item.first_index;
        end
        for (int k = 0; k < 3; k++)
        begin
            item_next.prod_first[k]  = PROD_W'({8'd0, in_color_first[k*COMP_W +: COMP_W]}
                                               * {7'd0, bar});
            item_next.prod_second[k] = PROD_W'({8'd0, in_color_second[k*COMP_W +: COMP_W]}
                                               * {7'd0, fac});
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: hdl/pbl_inverse_stage.sv
// ----------------------------------------------------------------------------
// pbl_inverse_stage
// Inverse palette memory and result register. Table writes land here, in
// item order with the blend reads.
// ----------------------------------------------------------------------------
module pbl_inverse_stage
    import pbl_pkg::*;
#(
    parameter int unsigned COMPONENT_BITS = DEF_COMPONENT_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mix_item_t        in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] out_index,
    output kind_t            out_kind
);

    localparam int unsigned INV_AW = 3 * COMPONENT_BITS;

    logic [IDX_W-1:0] inv_mem [1 << INV_AW];

    logic                         valid_reg;
    logic                         valid_next;
    kind_t                        kind_reg;
    logic [IDX_W-1:0]             keep_reg;
    logic [IDX_W-1:0]             lookup_reg;
    logic                         go;
    logic [INV_AW-1:0]            rd_addr;
    logic [INV_AW-1:0]            wr_addr;
    logic [INV_AW+TBL_ADDR_W-1:0] wr_addr_wide;
    logic [PROD_W-1:0]            mix_sum;

    assign in_ready     = !valid_reg || out_ready;
    assign go           = in_valid && in_ready;
    assign wr_addr_wide = {{INV_AW{1'b0}}, in_item.table_address};
    assign wr_addr      = wr_addr_wide[INV_AW-1:0];

    always_comb
    begin
        rd_addr = '0;
        mix_sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            mix_sum = in_item.prod_first[k] + in_item.prod_second[k];
            rd_addr[k*COMPONENT_BITS +: COMPONENT_BITS] =
                mix_sum[PROD_W-1 -: COMPONENT_BITS];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (go && in_item.mode == MODE_BLEND)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            lookup_reg <= inv_mem[rd_addr];
            if (in_item.mode == MODE_INV_WR)
            begin
                inv_mem[wr_addr] <= in_item.table_value;
            end
            if (in_item.mode == MODE_BLEND)
            begin
                kind_reg <= in_item.kind;
                keep_reg <= in_item.keep_index;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_index = (kind_reg == KIND_BLEND) ? lookup_reg : keep_reg;

endmodule
